### rtl/core/humidity_temp_frame_decoder_core_assert.svh
// Assertion macros shared by the frame decoder checkers.
// Needs nothing else; pulled in by `include where assertions are written.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_CORE_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_CORE_ASSERT_SVH

// Property holds on every clock edge outside reset.
`define HTFD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define HTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/htfd_pkg.sv
// Shared constants, result codes and the CRC-8 byte step for the frame decoder.
// No dependencies; used by the core and its checker.
`default_nettype none

package htfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // result status codes
  localparam logic [1:0] RES_OK      = 2'd0;
  localparam logic [1:0] RES_BUSY    = 2'd1;
  localparam logic [1:0] RES_CRC_ERR = 2'd2;

  // byte positions within a frame
  localparam logic [2:0] POS_IDLE   = 3'd0;
  localparam logic [2:0] POS_HUM_HI = 3'd1;
  localparam logic [2:0] POS_HUM_MD = 3'd2;
  localparam logic [2:0] POS_SPLIT  = 3'd3;
  localparam logic [2:0] POS_TMP_MD = 3'd4;
  localparam logic [2:0] POS_TMP_LO = 3'd5;
  localparam logic [2:0] POS_CRC    = 3'd6;

  localparam logic [0:0] KIND_NO_CRC = 1'b0;
  localparam logic [0:0] KIND_CRC    = 1'b1;
  localparam logic [0:0] KIND_RESET  = KIND_CRC;

  // fixed-point scaling
  localparam logic [33:0] HUM_SCALE      = 34'd10000;
  localparam logic [34:0] TMP_SCALE      = 35'd20000;
  localparam logic [14:0] TMP_OFFSET     = 15'd5000;
  localparam logic [13:0] HUM_CENTI_MAX  = 14'd10000;

  localparam int unsigned OUT_DATA_W = 72;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/humidity_temp_frame_decoder_core.sv
// Decoder for a humidity/temperature sensor measurement frame, one byte per transfer.
// Depends on htfd_pkg (codes, CRC-8 step, scaling constants).
//
//   channel | dir | payload
//   in_     | in  | tdata: rx_byte[7:0]; tuser: frame_start
//   out_    | out | tdata: status, humidity raw/centi, temperature raw/centi
//   cfg_    | in  | data: sensor_kind
//
// One byte per cycle while in_tready is high; a result appears in the output register
// the cycle after the last byte of a frame is accepted. The byte path (CRC step, field
// shifts, constant multipliers) is one register stage deep.
// Reset (rst_n low, synchronous) clears frame position, sets CRC to 0xFF and kind to 1.
// in_tready drops only while a result is held and out_tready is low.
`default_nettype none

module humidity_temp_frame_decoder_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // [7:0] rx_byte
  input  wire logic                              in_tuser,   // [0] frame_start
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [1:0] result_status, [22:2] humidity_raw, [42:23] temperature_raw,
  // [56:43] humidity_centi_pct, [71:57] temperature_centi_c
  output logic [htfd_pkg::OUT_DATA_W-1:0]        out_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_data
);
  import htfd_pkg::*;

  logic [0:0]  kind_r;
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  stat_r, stat_nxt;
  logic [19:0] hum_r, hum_nxt;
  logic [19:0] tmp_r, tmp_nxt;
  logic        emit;
  logic [1:0]  res_status;

  logic        out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic        accept;
  logic [33:0] hum_prod;
  logic [34:0] tmp_prod;
  logic [14:0] tmp_centi;
  logic [7:0]  b;

  assign b         = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    stat_nxt   = stat_r;
    hum_nxt    = hum_r;
    tmp_nxt    = tmp_r;
    emit       = 1'b0;
    res_status = stat_r[7] ? RES_BUSY : RES_OK;
    if (in_tuser) begin
      stat_nxt = b;
      crc_nxt  = crc8_step(CRC_INIT, b);
      hum_nxt  = '0;
      tmp_nxt  = '0;
      pos_nxt  = POS_HUM_HI;
    end else begin
      unique case (pos_r)
        POS_HUM_HI: hum_nxt = {b, 12'd0};
        POS_HUM_MD: hum_nxt = hum_r | {8'd0, b, 4'd0};
        POS_SPLIT: begin
          hum_nxt = hum_r | {16'd0, b[7:4]};
          tmp_nxt = {b[3:0], 16'd0};
        end
        POS_TMP_MD: tmp_nxt = tmp_r | {4'd0, b, 8'd0};
        POS_TMP_LO: tmp_nxt = tmp_r | {12'd0, b};
        POS_CRC: begin
          pos_nxt = POS_IDLE;
          emit    = 1'b1;
          // CRC byte only checked if the newer kind is still selected
          if (!stat_r[7] && kind_r == KIND_CRC && crc_r != b) begin
            res_status = RES_CRC_ERR;
          end
        end
        default: pos_nxt = POS_IDLE;  // stray byte between frames
      endcase
      if (pos_r != POS_IDLE && pos_r < POS_CRC) begin
        crc_nxt = crc8_step(crc_r, b);
        if (pos_r == POS_TMP_LO && kind_r == KIND_NO_CRC) begin
          pos_nxt = POS_IDLE;
          emit    = 1'b1;
        end else begin
          pos_nxt = pos_r + 3'd1;
        end
      end
    end
  end

  // 20-bit code never exceeds 0x100000, so the humidity clamp is a no-op
  assign hum_prod  = {14'd0, hum_nxt} * HUM_SCALE;
  assign tmp_prod  = {15'd0, tmp_nxt} * TMP_SCALE;
  assign tmp_centi = tmp_prod[34:20] - TMP_OFFSET;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= KIND_RESET;
      pos_r       <= POS_IDLE;
      crc_r       <= CRC_INIT;
      stat_r      <= '0;
      hum_r       <= '0;
      tmp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        kind_r <= cfg_data;
      end
      if (accept) begin
        pos_r  <= pos_nxt;
        crc_r  <= crc_nxt;
        stat_r <= stat_nxt;
        hum_r  <= hum_nxt;
        tmp_r  <= tmp_nxt;
      end
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data_r <= {tmp_centi, hum_prod[33:20], tmp_nxt, {1'b0, hum_nxt}, res_status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

### rtl/core/htfd_checker.sv
// Port-level checker for the frame decoder core, bound to the top level below.
// Depends on htfd_pkg and humidity_temp_frame_decoder_core_assert.svh.
`default_nettype none
`include "humidity_temp_frame_decoder_core_assert.svh"

module htfd_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tvalid,
  input wire logic                       in_tready,
  input wire logic                       in_tuser,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [htfd_pkg::OUT_DATA_W-1:0] out_tdata
);
  import htfd_pkg::*;

  logic        in_xfer;
  logic        out_free;
  logic        out_stall;
  logic        start_xfer;
  logic        code_ok;
  logic [13:0] hum_centi;

  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid || out_tready;
  assign out_stall  = out_tvalid && !out_tready;
  assign start_xfer = in_xfer && in_tuser && out_free;
  assign code_ok    = out_tdata[1:0] == RES_OK || out_tdata[1:0] == RES_BUSY ||
                      out_tdata[1:0] == RES_CRC_ERR;
  assign hum_centi  = out_tdata[56:43];

  // held result must not be dropped or changed
  `HTFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata),
                    "result changed while stalled")

  // a frame start never produces a result
  `HTFD_ASSERT_NEXT(a_start_silent, clk, rst_n, start_xfer, !out_tvalid,
                    "result after frame start")

  // input stalls only behind a held result
  `HTFD_ASSERT(a_ready, clk, rst_n, out_free == in_tready,
               "input ready not tied to output slot")

  `HTFD_ASSERT(a_status_code, clk, rst_n, !out_tvalid || code_ok, "bad result status")

  `HTFD_ASSERT(a_hum_range, clk, rst_n, !out_tvalid || hum_centi <= HUM_CENTI_MAX,
               "humidity out of range")

endmodule

bind humidity_temp_frame_decoder_core htfd_checker u_htfd_checker (.*);

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking bench for humidity_temp_frame_decoder_core: sensor reply bytes in, one
// decoded measurement per frame out, scored against a bit-accurate decoder model.
// Depends on htfd_pkg for result codes, byte positions, sensor kinds and the CRC polynomial.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import htfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASE_BYTES = 200;

  // packed so that the layout matches out_tdata, lowest field last
  typedef struct packed {
    logic signed [14:0] temperature_centi_c;
    logic [13:0]        humidity_centi_pct;
    logic [19:0]        temperature_raw;
    logic [20:0]        humidity_raw;
    logic [1:0]         result_status;
  } meas_t;

  typedef enum logic [1:0] {ROW_BYTE, ROW_CRC_GOOD, ROW_CRC_BAD, ROW_SET_KIND} row_op_t;

  typedef struct packed {
    row_op_t    op;
    logic [7:0] data;
    logic       start;
    logic [1:0] typed_id;  // 0: score against the decoder model
  } dir_row_t;

  // results that can be read straight off the frame contents
  localparam meas_t TYPED_RES [3] = '{
    '0,
    '{-15'sd5000, 14'd0, 20'd0, 21'd0, RES_BUSY},  // busy frame, all data zero
    '{-15'sd5000, 14'd0, 20'd0, 21'd0, RES_OK}     // short frame, all zero
  };

  localparam dir_row_t DIR_ROWS [32] = '{
    // stray byte while waiting for a start
    '{ROW_BYTE, 8'h55, 1'b0, 2'd0},
    // busy status, zero data, CRC byte not looked at
    '{ROW_BYTE, 8'h80, 1'b1, 2'd0}, '{ROW_BYTE, 8'h00, 1'b0, 2'd0},
    '{ROW_BYTE, 8'h00, 1'b0, 2'd0}, '{ROW_BYTE, 8'h00, 1'b0, 2'd0},
    '{ROW_BYTE, 8'h00, 1'b0, 2'd0}, '{ROW_BYTE, 8'h00, 1'b0, 2'd0},
    '{ROW_BYTE, 8'h5A, 1'b0, 2'd1},
    // partial frame dropped by a new start, then a clean frame
    '{ROW_BYTE, 8'h3C, 1'b1, 2'd0}, '{ROW_BYTE, 8'hA5, 1'b0, 2'd0},
    '{ROW_BYTE, 8'h12, 1'b1, 2'd0}, '{ROW_BYTE, 8'h34, 1'b0, 2'd0},
    '{ROW_BYTE, 8'h56, 1'b0, 2'd0}, '{ROW_BYTE, 8'h78, 1'b0, 2'd0},
    '{ROW_BYTE, 8'h9A, 1'b0, 2'd0}, '{ROW_BYTE, 8'hBC, 1'b0, 2'd0},
    '{ROW_CRC_GOOD, 8'h00, 1'b0, 2'd0},
    // full-scale codes with a corrupted CRC
    '{ROW_BYTE, 8'h00, 1'b1, 2'd0}, '{ROW_BYTE, 8'hFF, 1'b0, 2'd0},
    '{ROW_BYTE, 8'hFF, 1'b0, 2'd0}, '{ROW_BYTE, 8'hFF, 1'b0, 2'd0},
    '{ROW_BYTE, 8'hFF, 1'b0, 2'd0}, '{ROW_BYTE, 8'hFF, 1'b0, 2'd0},
    '{ROW_CRC_BAD, 8'h00, 1'b0, 2'd0},
    // switch to the short frame in the middle of a frame
    '{ROW_BYTE, 8'h00, 1'b1, 2'd0}, '{ROW_BYTE, 8'h00, 1'b0, 2'd0},
    '{ROW_BYTE, 8'h00, 1'b0, 2'd0}, '{ROW_SET_KIND, 8'h00, 1'b0, 2'd0},
    '{ROW_BYTE, 8'h00, 1'b0, 2'd0}, '{ROW_BYTE, 8'h00, 1'b0, 2'd0},
    '{ROW_BYTE, 8'h00, 1'b0, 2'd2},
    '{ROW_BYTE, 8'h33, 1'b0, 2'd0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic        in_tuser;   // [0] frame_start
  logic        out_tvalid;
  logic        out_tready;
  // [1:0] result_status, [22:2] humidity_raw, [42:23] temperature_raw,
  // [56:43] humidity_centi_pct, [71:57] temperature_centi_c
  logic [OUT_DATA_W-1:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  // decoder model state
  logic [0:0]  dec_kind;
  logic [2:0]  dec_pos;
  logic [7:0]  dec_crc;
  logic [7:0]  dec_status;
  logic [19:0] dec_hum;
  logic [19:0] dec_tmp;

  meas_t       meas_q [$];
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned hold_len;
  int unsigned bytes_used;
  int unsigned meas_seen;
  int unsigned mismatches;
  int unsigned cycles;

  humidity_temp_frame_decoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [7:0] crc31(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  // Advance the model by one accepted byte; returns 1 when it closes a frame.
  function automatic bit decode_byte(input logic [7:0] b, input logic s, output meas_t r);
    logic [1:0]  st;
    logic [20:0] h;
    logic [63:0] hc;
    logic [63:0] tc;
    r = '0;
    if (s) begin
      dec_status = b;
      dec_crc    = crc31(CRC_INIT, b);
      dec_hum    = '0;
      dec_tmp    = '0;
      dec_pos    = POS_HUM_HI;
      return 1'b0;
    end
    case (dec_pos)
      POS_IDLE:   return 1'b0;
      POS_HUM_HI: dec_hum = {b, 12'h000};
      POS_HUM_MD: dec_hum = dec_hum | {8'h00, b, 4'h0};
      POS_SPLIT: begin
        dec_hum = dec_hum | {16'h0000, b[7:4]};
        dec_tmp = {b[3:0], 16'h0000};
      end
      POS_TMP_MD: dec_tmp = dec_tmp | {4'h0, b, 8'h00};
      POS_TMP_LO: dec_tmp = dec_tmp | {12'h000, b};
      default: ;
    endcase
    st = dec_status[7] ? RES_BUSY : RES_OK;
    if (dec_pos != POS_CRC) begin
      dec_crc = crc31(dec_crc, b);
      if (!(dec_pos == POS_TMP_LO && dec_kind == KIND_NO_CRC)) begin
        dec_pos = dec_pos + 3'd1;
        return 1'b0;
      end
    end else if (!dec_status[7] && dec_kind == KIND_CRC && dec_crc != b) begin
      st = RES_CRC_ERR;
    end
    dec_pos = POS_IDLE;
    h = {1'b0, dec_hum};
    if (h > 21'h100000) h = 21'h100000;
    hc = (64'(h) * 64'd10000) >> 20;
    tc = ((64'(dec_tmp) * 64'd20000) >> 20) - 64'd5000;
    r.result_status       = st;
    r.humidity_raw        = h;
    r.temperature_raw     = dec_tmp;
    r.humidity_centi_pct  = hc[13:0];
    r.temperature_centi_c = tc[14:0];
    return 1'b1;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic s, input logic [1:0] typed_id);
    meas_t r;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= s;
    do @(posedge clk); while (!in_tready);
    if (s || dec_pos != POS_IDLE) bytes_used++;
    if (decode_byte(b, s, r)) meas_q.push_back(typed_id != 2'd0 ? TYPED_RES[typed_id] : r);
  endtask

  // only between frames' results; a frame still in progress carries on under the new kind
  task automatic write_kind(input logic [0:0] kind);
    in_tvalid <= 1'b0;
    while (meas_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= kind;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dec_kind = kind;
  endtask

  // run the current frame to its end, mostly with a correct CRC byte
  task automatic finish_frame();
    logic [7:0] b;
    while (dec_pos != POS_IDLE) begin
      b = 8'($urandom);
      if (dec_pos == POS_CRC && $urandom_range(99) >= 15) b = dec_crc;
      send_item(b, 1'b0, 2'd0);
    end
  endtask

  // output side: random back-pressure, long hold-off on request, result scoring
  initial begin
    meas_t got;
    meas_t want;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = meas_t'(out_tdata);
        meas_seen++;
        if (meas_q.size() == 0) begin
          $error("unexpected result transfer: %h", out_tdata);
          mismatches++;
        end else begin
          want = meas_q.pop_front();
          if (got.result_status !== want.result_status) begin
            $error("result_status: expected %0d, got %0d",
                   want.result_status, got.result_status);
            mismatches++;
          end
          if (got.humidity_raw !== want.humidity_raw) begin
            $error("humidity_raw: expected %h, got %h", want.humidity_raw, got.humidity_raw);
            mismatches++;
          end
          if (got.temperature_raw !== want.temperature_raw) begin
            $error("temperature_raw: expected %h, got %h",
                   want.temperature_raw, got.temperature_raw);
            mismatches++;
          end
          if (got.humidity_centi_pct !== want.humidity_centi_pct) begin
            $error("humidity_centi_pct: expected %0d, got %0d",
                   want.humidity_centi_pct, got.humidity_centi_pct);
            mismatches++;
          end
          if (got.temperature_centi_c !== want.temperature_centi_c) begin
            $error("temperature_centi_c: expected %0d, got %0d",
                   want.temperature_centi_c, got.temperature_centi_c);
            mismatches++;
          end
        end
      end
      if (hold_len > 0) begin
        hold_len--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    logic [7:0] st;
    logic [7:0] fill;
    int unsigned target;
    bit drained;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    send_idle  = 0;
    recv_idle  = 0;
    hold_len   = 0;
    bytes_used = 0;
    meas_seen  = 0;
    mismatches = 0;
    dec_kind   = KIND_RESET;
    dec_pos    = POS_IDLE;
    dec_crc    = CRC_INIT;
    dec_status = '0;
    dec_hum    = '0;
    dec_tmp    = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      case (DIR_ROWS[i].op)
        ROW_SET_KIND: write_kind(DIR_ROWS[i].data[0]);
        ROW_CRC_GOOD: send_item(dec_crc, 1'b0, DIR_ROWS[i].typed_id);
        ROW_CRC_BAD:  send_item(~dec_crc, 1'b0, DIR_ROWS[i].typed_id);
        default:      send_item(DIR_ROWS[i].data, DIR_ROWS[i].start, DIR_ROWS[i].typed_id);
      endcase
    end

    for (int p = 0; p < 8; p++) begin
      send_idle = (p < 3) ? 18 : (p < 6) ? 86 : 0;
      recv_idle = (p < 3) ? 86 : (p < 6) ? 18 : 0;
      // a frame cut at the end of the last phase resumes under the new kind
      write_kind(p[0] ? KIND_NO_CRC : KIND_CRC);
      if (p == 1) hold_len = 300;
      finish_frame();
      target  = bytes_used + PHASE_BYTES;
      drained = 1'b0;
      while (bytes_used < target) begin
        if (p == 4 && !drained && bytes_used + 100 >= target) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (meas_q.size() != 0);
          drained = 1'b1;
        end
        st = {($urandom_range(99) < 20), 7'($urandom)};
        case ($urandom_range(9))
          0: send_item(8'($urandom), 1'b0, 2'd0);
          1: begin
            send_item(st, 1'b1, 2'd0);
            repeat ($urandom_range(4)) send_item(8'($urandom), 1'b0, 2'd0);
          end
          2: begin
            fill = $urandom_range(1) ? 8'hFF : 8'h00;
            send_item(st, 1'b1, 2'd0);
            repeat (5) send_item(fill, 1'b0, 2'd0);
            finish_frame();
          end
          default: begin
            send_item(st, 1'b1, 2'd0);
            finish_frame();
          end
        endcase
      end
      if ($urandom_range(1)) begin
        send_item({($urandom_range(99) < 20), 7'($urandom)}, 1'b1, 2'd0);
        repeat ($urandom_range(4)) send_item(8'($urandom), 1'b0, 2'd0);
      end
    end

    in_tvalid <= 1'b0;
    while (meas_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Frames decoded: %0d from %0d frame bytes, both sensor kinds,", meas_seen,
             bytes_used);
    $display("kind switches inside frames, busy/CRC-error/ok, stalls and a long hold-off.");
    if (mismatches + meas_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
